// ----- sv/kpnc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpnc_pkg
// Shared codes and controller/datapath interface types for the keyword pair
// nesting checker.
// ----------------------------------------------------------------------------
package kpnc_pkg;

   // request types
   localparam logic REQ_WORD = 1'b0;
   localparam logic REQ_EOT  = 1'b1;

   // word kinds
   localparam logic [2:0] KIND_BEGIN = 3'd0;
   localparam logic [2:0] KIND_END   = 3'd1;
   localparam logic [2:0] KIND_IF    = 3'd2;
   localparam logic [2:0] KIND_THEN  = 3'd3;
   localparam logic [2:0] KIND_ELSE  = 3'd4;

   // stack marks
   localparam logic [1:0] MARK_BEGIN = 2'd0;
   localparam logic [1:0] MARK_IF    = 2'd1;
   localparam logic [1:0] MARK_THEN  = 2'd2;

   // response status
   localparam logic [1:0] ST_TAKEN    = 2'd0;
   localparam logic [1:0] ST_MISMATCH = 2'd1;
   localparam logic [1:0] ST_CORRECT  = 2'd2;
   localparam logic [1:0] ST_ERROR    = 2'd3;

   typedef enum logic {
      STATE_IDLE,
      STATE_EXEC
   } state_type;

   typedef struct packed {
      logic accept;     // latch request beat
      logic pop_pair;   // drop one then-over-if pair
      logic finish;     // apply item, load response register
   } cmd_type;

   typedef struct packed {
      logic drain;      // a then-over-if pair must come off before finishing
   } stat_type;

endpackage
`default_nettype wire

// ----- sv/kpnc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpnc_ctrl
// Sequencer: accepts a request beat, drains then/if pairs one per cycle,
// then finishes the item into the response register.
// ----------------------------------------------------------------------------
module kpnc_ctrl
   import kpnc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == STATE_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         STATE_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = STATE_EXEC;
            end
         end
         STATE_EXEC: begin
            if (stat.drain) begin
               cmd.pop_pair = 1'b1;
            end else if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = STATE_IDLE;
            end
         end
         default: state_in = STATE_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ----- sv/kpnc_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpnc_dpath
// Mark stack memory with two registered read ports (top and second), fill
// count, sticky error state and response register.
// ----------------------------------------------------------------------------
module kpnc_dpath
   import kpnc_pkg::*;
#(
   parameter int STACK_DEPTH = 64
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_type,
   input  wire logic [2:0]  req_word_kind,
   input  wire logic [15:0] req_line_number,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_error_line
);

   localparam int PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   logic [1:0] mem [STACK_DEPTH];

   logic             type_ff;
   logic [2:0]       kind_ff;
   logic [15:0]      line_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             failed_ff, failed_in;
   logic [15:0]      failed_line_ff, failed_line_in;
   logic [1:0]       top_ff, second_ff;
   logic [1:0]       status_ff, status_in;
   logic [15:0]      eline_ff, eline_in;

   logic             wr_en;
   logic [1:0]       wr_mark;
   logic             push_en;
   logic [1:0]       push_mark;
   logic             viol;
   logic             pair_on_top;
   logic [CNT_W-1:0] top_idx, sec_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         failed_ff      <= 1'b0;
         failed_line_ff <= '0;
      end else begin
         count_ff       <= count_in;
         failed_ff      <= failed_in;
         failed_line_ff <= failed_line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         type_ff <= req_type;
         kind_ff <= req_word_kind;
         line_ff <= req_line_number;
      end
      if (cmd.finish) begin
         status_ff <= status_in;
         eline_ff  <= eline_in;
      end
   end

   // stack memory; reads follow the next count so data tracks the top
   assign top_idx = count_in - CNT_W'(1);
   assign sec_idx = count_in - CNT_W'(2);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[PTR_W-1:0]] <= wr_mark;
      end
      top_ff    <= mem[top_idx[PTR_W-1:0]];
      second_ff <= mem[sec_idx[PTR_W-1:0]];
   end

   assign pair_on_top = (count_ff >= CNT_W'(2)) && (top_ff == MARK_THEN) &&
                        (second_ff == MARK_IF);
   assign stat.drain  = !failed_ff && ((type_ff == REQ_EOT) || (kind_ff == KIND_END)) &&
                        pair_on_top;

   always_comb begin
      count_in       = count_ff;
      failed_in      = failed_ff;
      failed_line_in = failed_line_ff;
      status_in      = ST_TAKEN;
      eline_in       = '0;
      wr_en          = 1'b0;
      wr_mark        = MARK_BEGIN;
      push_en        = 1'b0;
      push_mark      = MARK_BEGIN;
      viol           = 1'b0;

      if (cmd.pop_pair) begin
         count_in = count_ff - CNT_W'(2);
      end else if (cmd.finish) begin
         if (type_ff == REQ_EOT) begin
            if (failed_ff) begin
               status_in = ST_ERROR;
               eline_in  = failed_line_ff;
            end else if (count_ff == '0) begin
               status_in = ST_CORRECT;
            end else begin
               status_in = ST_ERROR;
               eline_in  = line_ff;
            end
            count_in       = '0;
            failed_in      = 1'b0;
            failed_line_in = '0;
         end else if (!failed_ff) begin
            unique case (kind_ff)
               KIND_BEGIN: begin
                  push_en   = 1'b1;
                  push_mark = MARK_BEGIN;
               end
               KIND_IF: begin
                  push_en   = 1'b1;
                  push_mark = MARK_IF;
               end
               KIND_END: begin
                  if ((count_ff == '0) || (top_ff != MARK_BEGIN)) begin
                     viol = 1'b1;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               KIND_THEN: begin
                  if ((count_ff == '0) || (top_ff != MARK_IF)) begin
                     viol = 1'b1;
                  end else begin
                     push_en   = 1'b1;
                     push_mark = MARK_THEN;
                  end
               end
               KIND_ELSE: begin
                  if ((count_ff < CNT_W'(2)) || (top_ff != MARK_THEN)) begin
                     viol = 1'b1;
                  end else begin
                     count_in = count_ff - CNT_W'(2);
                  end
               end
               default: ;
            endcase

            if (push_en) begin
               if (count_ff == CNT_W'(STACK_DEPTH)) begin
                  viol = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  wr_mark  = push_mark;
                  count_in = count_ff + CNT_W'(1);
               end
            end

            if (viol) begin
               failed_in      = 1'b1;
               failed_line_in = line_ff;
               status_in      = ST_MISMATCH;
            end
         end
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_error_line = eline_ff;

endmodule
`default_nettype wire

// ----- sv/keyword_pair_nesting_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyword_pair_nesting_checker
// Checks begin/end and if/then/else nesting of a stream of classified words.
// ----------------------------------------------------------------------------
// Each request beat is one word (begin, end, if, then, else, other) with its
// line number, or an end-of-text marker. Every beat yields exactly one
// response beat: word taken, mismatch at this word, text correct, or text in
// error with the first violation's line, or the end-of-text line if marks are
// left open. The first violation is sticky until end of text, which returns
// all state to its reset values. Open marks live in a STACK_DEPTH-entry
// memory; pushing past it is a violation. An item is accepted, drops each
// then-over-if pair that an end or end-of-text uncovers (a loop bound by the
// registered top/second stack read) and finishes once the output register is
// free. A new beat is accepted the cycle after the previous one finishes,
// while its response may still wait in the output register.
// ----------------------------------------------------------------------------
module keyword_pair_nesting_checker
   import kpnc_pkg::*;
#(
   parameter int STACK_DEPTH = 64
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_type,
   input  wire logic [2:0]  req_word_kind,
   input  wire logic [15:0] req_line_number,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_error_line
);

   cmd_type  cmd;
   stat_type stat;

   kpnc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   kpnc_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_type        (req_type),
      .req_word_kind   (req_word_kind),
      .req_line_number (req_line_number),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (rsp_status),
      .rsp_error_line  (rsp_error_line)
   );

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyword pair nesting checker.
// ----------------------------------------------------------------------------
// A short directed set of texts covers the corners: every word kind, the
// unused kind codes, a violation at line zero, unclosed marks, and then/if
// pairs left open at end of text. Random texts follow. Most are well-nested
// programs with random content. Some are deep texts that fill the stack or
// drop long runs of then/if pairs, and a few are pure noise. A behavioral
// nesting model predicts each response beat, and the responses are checked
// in order against it. Sender and receiver idle at random in phases, and the
// receiver holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_top
   import kpnc_pkg::*;
();

   localparam int STACK_DEPTH  = 64;
   localparam int WORD_TARGET  = 1750;
   localparam int WATCHDOG_MAX = 3000;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_AT      = 120;
   localparam int HOLD_CYCLES  = 120;
   localparam int PHASE_LEN    = 150;

   localparam logic [2:0] KIND_OTHER  = 3'd5;
   localparam logic [2:0] KIND_SPARE6 = 3'd6;
   localparam logic [2:0] KIND_SPARE7 = 3'd7;

   typedef struct packed {
      logic        rtype;
      logic [2:0]  kind;
      logic [15:0] line;
   } word_beat_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] error_line;
   } verdict_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic        req_type        = REQ_WORD;
   logic [2:0]  req_word_kind   = KIND_BEGIN;
   logic [15:0] req_line_number = '0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_error_line;

   word_beat_type word_queue[$];
   verdict_type   verdict_queue[$];
   word_beat_type next_beat;
   verdict_type   want;

   // nesting model state
   logic [1:0]  mark_stack [STACK_DEPTH];
   logic [6:0]  mark_depth     = '0;
   bit          nest_failed    = 1'b0;
   logic [15:0] nest_fail_line = '0;

   // stimulus generation state
   logic [15:0] gen_line   = '0;
   bit          gen_broken = 1'b0;
   int          live_words = 0;

   bit offer_busy = 1'b0;
   bit hold_done  = 1'b0;
   int hold_left  = 0;
   int idle_cycles = 0;
   int beats_in = 0;
   int error_count = 0;
   int overflow_hits = 0;
   int texts_correct = 0;
   int texts_in_error = 0;
   int mismatch_beats = 0;

   keyword_pair_nesting_checker #(.STACK_DEPTH(STACK_DEPTH)) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_word_kind   (req_word_kind),
      .req_line_number (req_line_number),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_error_line  (rsp_error_line)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------- nesting model ----------------

   function automatic bit mark_push(logic [1:0] mark);
      if (mark_depth >= STACK_DEPTH) begin
         overflow_hits++;
         return 1'b0;
      end
      mark_stack[mark_depth] = mark;
      mark_depth++;
      return 1'b1;
   endfunction

   function automatic void drop_then_pairs();
      while (mark_depth >= 2 && mark_stack[mark_depth - 1] == MARK_THEN &&
             mark_stack[mark_depth - 2] == MARK_IF)
         mark_depth -= 2;
   endfunction

   // returns 0 on a nesting violation
   function automatic bit apply_word(logic [2:0] kind);
      case (kind)
         KIND_BEGIN: return mark_push(MARK_BEGIN);
         KIND_IF:    return mark_push(MARK_IF);
         KIND_END: begin
            drop_then_pairs();
            if (mark_depth == 0 || mark_stack[mark_depth - 1] != MARK_BEGIN)
               return 1'b0;
            mark_depth--;
            return 1'b1;
         end
         KIND_THEN: begin
            if (mark_depth == 0 || mark_stack[mark_depth - 1] != MARK_IF)
               return 1'b0;
            return mark_push(MARK_THEN);
         end
         KIND_ELSE: begin
            if (mark_depth < 2 || mark_stack[mark_depth - 1] != MARK_THEN)
               return 1'b0;
            mark_depth -= 2;
            return 1'b1;
         end
         default: return 1'b1;
      endcase
   endfunction

   function automatic verdict_type predict_verdict(word_beat_type beat);
      verdict_type v;
      v.status     = ST_TAKEN;
      v.error_line = '0;
      if (beat.rtype == REQ_WORD) begin
         // words after the first violation are ignored
         if (!nest_failed && !apply_word(beat.kind)) begin
            nest_failed    = 1'b1;
            nest_fail_line = beat.line;
            v.status       = ST_MISMATCH;
         end
      end else begin
         if (nest_failed) begin
            v.status     = ST_ERROR;
            v.error_line = nest_fail_line;
         end else begin
            drop_then_pairs();
            if (mark_depth == 0) begin
               v.status = ST_CORRECT;
            end else begin
               v.status     = ST_ERROR;
               v.error_line = beat.line;
            end
         end
         foreach (mark_stack[i]) mark_stack[i] = MARK_BEGIN;
         mark_depth     = '0;
         nest_failed    = 1'b0;
         nest_fail_line = '0;
      end
      return v;
   endfunction

   // ---------------- stimulus ----------------

   task automatic queue_beat(logic rtype, logic [2:0] kind, logic [15:0] line);
      word_beat_type beat;
      beat.rtype = rtype;
      beat.kind  = kind;
      beat.line  = line;
      word_queue.insert(word_queue.size(), beat);
      if (!gen_broken) live_words++;
   endtask

   task automatic rand_word(logic [2:0] kind);
      gen_line = gen_line + 16'($urandom_range(0, 3));
      queue_beat(REQ_WORD, kind, gen_line);
   endtask

   task automatic rand_eot();
      gen_broken = 1'b0;
      gen_line   = gen_line + 16'($urandom_range(0, 2));
      queue_beat(REQ_EOT, 3'($urandom_range(0, 7)), gen_line);
      gen_line = 16'($urandom);
   endtask

   // well-nested program with random content; rarely corrupted or left open
   task automatic gen_nested_text();
      logic [1:0] nest_plan[$];
      int         n_words;
      int         choice;
      bit         corrupt;
      bit         has_begin;
      n_words = $urandom_range(2, 40);
      corrupt = ($urandom_range(0, 9) == 0);
      repeat (n_words) begin
         has_begin = 1'b0;
         foreach (nest_plan[i])
            if (nest_plan[i] == MARK_BEGIN) has_begin = 1'b1;
         choice = $urandom_range(0, 99);
         if (choice < 22 && nest_plan.size() < 24) begin
            rand_word(KIND_BEGIN);
            nest_plan.insert(nest_plan.size(), MARK_BEGIN);
         end else if (choice < 42 && nest_plan.size() < 24) begin
            rand_word(KIND_IF);
            if ($urandom_range(0, 3) == 0) rand_word(KIND_OTHER);
            rand_word(KIND_THEN);
            nest_plan.insert(nest_plan.size(), MARK_THEN);
         end else if (choice < 56 && nest_plan.size() > 0 && nest_plan[$] == MARK_THEN) begin
            rand_word(KIND_ELSE);
            nest_plan.delete(nest_plan.size() - 1);
         end else if (choice < 76 && has_begin) begin
            // end closes any then/if pairs above the begin
            while (nest_plan[$] == MARK_THEN) nest_plan.delete(nest_plan.size() - 1);
            nest_plan.delete(nest_plan.size() - 1);
            rand_word(KIND_END);
         end else if (corrupt && choice > 95) begin
            rand_word(3'($urandom_range(0, 7)));
         end else begin
            case ($urandom_range(0, 5))
               0:       rand_word(KIND_SPARE6);
               1:       rand_word(KIND_SPARE7);
               default: rand_word(KIND_OTHER);
            endcase
         end
      end
      if ($urandom_range(0, 9) != 0) begin
         while (nest_plan.size() > 0) begin
            if (nest_plan[$] == MARK_THEN) begin
               if ($urandom_range(0, 1)) rand_word(KIND_ELSE);
            end else begin
               rand_word(KIND_END);
            end
            nest_plan.delete(nest_plan.size() - 1);
         end
      end
      rand_eot();
   endtask

   // fills the stack or leaves long runs of then/if pairs to drop
   task automatic gen_deep_text();
      int n;
      case ($urandom_range(0, 2))
         0: begin
            n = $urandom_range(60, 68);
            for (int i = 0; i < n; i++) begin
               rand_word($urandom_range(0, 3) == 0 ? KIND_IF : KIND_BEGIN);
               if (i == STACK_DEPTH) gen_broken = 1'b1;
            end
            repeat ($urandom_range(0, 8)) rand_word(KIND_END);
         end
         1: begin
            rand_word(KIND_BEGIN);
            repeat ($urandom_range(20, 31)) begin
               rand_word(KIND_IF);
               rand_word(KIND_THEN);
            end
            rand_word(KIND_END);
         end
         default: begin
            repeat ($urandom_range(28, 32)) begin
               rand_word(KIND_IF);
               rand_word(KIND_THEN);
            end
            if ($urandom_range(0, 1)) rand_word(KIND_IF);
         end
      endcase
      rand_eot();
   endtask

   task automatic gen_noise_text();
      repeat ($urandom_range(1, 10))
         queue_beat(REQ_WORD, 3'($urandom_range(0, 7)), 16'($urandom));
      gen_broken = 1'b0;
      queue_beat(REQ_EOT, 3'($urandom_range(0, 7)), 16'($urandom));
   endtask

   task automatic build_stimulus();
      int pick;
      // nested else, end over pairs, spare kinds: correct text
      queue_beat(REQ_WORD, KIND_BEGIN,  16'h0000);
      queue_beat(REQ_WORD, KIND_IF,     16'h0001);
      queue_beat(REQ_WORD, KIND_THEN,   16'h0002);
      queue_beat(REQ_WORD, KIND_ELSE,   16'h0003);
      queue_beat(REQ_WORD, KIND_END,    16'h0004);
      queue_beat(REQ_WORD, KIND_BEGIN,  16'h0005);
      queue_beat(REQ_WORD, KIND_IF,     16'h0006);
      queue_beat(REQ_WORD, KIND_THEN,   16'h0007);
      queue_beat(REQ_WORD, KIND_END,    16'h0008);
      queue_beat(REQ_WORD, KIND_OTHER,  16'hFFFF);
      queue_beat(REQ_WORD, KIND_SPARE6, 16'hAAAA);
      queue_beat(REQ_WORD, KIND_SPARE7, 16'h5555);
      queue_beat(REQ_EOT,  KIND_BEGIN,  16'h0010);
      // violation at line zero, later word ignored
      queue_beat(REQ_WORD, KIND_THEN,   16'h0000);
      queue_beat(REQ_WORD, KIND_BEGIN,  16'h0001);
      queue_beat(REQ_EOT,  KIND_OTHER,  16'h0002);
      // unclosed begin
      queue_beat(REQ_WORD, KIND_BEGIN,  16'h1234);
      queue_beat(REQ_EOT,  KIND_SPARE7, 16'hFFFF);
      // open then/if pair dropped at end of text
      queue_beat(REQ_WORD, KIND_IF,     16'h0020);
      queue_beat(REQ_WORD, KIND_THEN,   16'h0021);
      queue_beat(REQ_EOT,  KIND_END,    16'h0022);
      // else without then
      queue_beat(REQ_WORD, KIND_IF,     16'h0030);
      queue_beat(REQ_WORD, KIND_ELSE,   16'h8000);
      queue_beat(REQ_EOT,  KIND_IF,     16'h0032);
      // end on an empty stack
      queue_beat(REQ_WORD, KIND_END,    16'h7FFF);
      queue_beat(REQ_EOT,  KIND_ELSE,   16'h0041);

      gen_line = 16'($urandom);
      while (live_words < WORD_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 78)      gen_nested_text();
         else if (pick < 88) gen_deep_text();
         else                gen_noise_text();
      end
   endtask

   // ---------------- idling phases ----------------

   function automatic int send_idle_pct();
      case ((beats_in / PHASE_LEN) % 4)
         1:       return 56;
         3:       return 28;
         default: return 0;
      endcase
   endfunction

   function automatic int stall_pct();
      case ((beats_in / PHASE_LEN) % 4)
         2:       return 56;
         3:       return 28;
         default: return 0;
      endcase
   endfunction

   // ---------------- driver ----------------

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!offer_busy) begin
         if (word_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
            next_beat = word_queue.pop_front();
            req_type        <= next_beat.rtype;
            req_word_kind   <= next_beat.kind;
            req_line_number <= next_beat.line;
            req_valid       <= 1'b1;
            offer_busy = 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver side: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (!hold_done && beats_in >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct());
      end
   end

   // ---------------- monitor and checker ----------------

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (verdict_queue.size() == 0) begin
               $error("response beat with nothing expected: status %0d, error_line %0d",
                      rsp_status, rsp_error_line);
               error_count++;
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_error_line !== want.error_line) begin
                  $error("error_line: expected %0d, got %0d", want.error_line,
                         rsp_error_line);
                  error_count++;
               end
               case (want.status)
                  ST_CORRECT:  texts_correct++;
                  ST_ERROR:    texts_in_error++;
                  ST_MISMATCH: mismatch_beats++;
                  default: ;
               endcase
            end
         end
         if (req_valid && req_ready) begin
            verdict_queue.insert(verdict_queue.size(),
                                 predict_verdict({req_type, req_word_kind,
                                                  req_line_number}));
            beats_in++;
            offer_busy = 1'b0;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX) begin
               $display("watchdog: no beat for %0d cycles, %0d responses outstanding",
                        idle_cycles, verdict_queue.size());
               $display("Testbench completed WITH ERRORS");
               $finish;
            end
         end
      end
   end

   // ---------------- sequence ----------------

   initial begin
      build_stimulus();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (word_queue.size() > 0 || offer_busy || verdict_queue.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (verdict_queue.size() > 0) begin
         $error("%0d expected responses never arrived", verdict_queue.size());
         error_count++;
      end
      $display("Covered %0d beats: %0d texts correct, %0d texts in error, %0d mismatch beats",
               beats_in, texts_correct, texts_in_error, mismatch_beats);
      $display("Stack overflows hit: %0d, failures found: %0d", overflow_hits, error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
